@@ hdl/pvt_pkg.sv @@
// Shared types and constants of the pinned vertex table.
// No dependencies; pvt_cell, pinned_vertex_table and the sim files import this package.
`default_nettype none

package pvt_pkg;

  // Float bit patterns written to a vertex while it is pinned
  localparam logic [31:0] PIN_MASS_BITS  = 32'h4B18967F;  // 9999999.0
  localparam logic [31:0] PIN_RECIP_BITS = 32'h00000000;  // 0.0

  localparam int unsigned VTOTAL_WIDTH = 21;
  localparam int unsigned COUNT_OUT_WIDTH = 7;

  typedef enum logic [0:0] {
    MODE_PIN   = 1'b0,
    MODE_UNPIN = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    ST_PINNED     = 3'd0,
    ST_ALREADY    = 3'd1,
    ST_RANGE      = 3'd2,
    ST_FULL       = 3'd3,
    ST_RESTORED   = 3'd4,
    ST_NOT_PINNED = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  // Control broadcast from the sequencer to every cell of the row
  typedef struct packed {
    logic capture;   // compare the incoming key against the cell entry
    logic shift_up;  // every cell takes the entry of its lower neighbor
    logic remove;    // cells at or above the hit take their upper neighbor
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/pvt_req_if.sv @@
// Request channel of the pinned vertex table: valid/ready plus payload.
// Depends on nothing; the index width is a parameter.
`default_nettype none

interface pvt_req_if #(
  parameter int unsigned INDEX_WIDTH = 20
);
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [INDEX_WIDTH-1:0] vtx_id;
  logic [31:0]            current_mass;
  logic [31:0]            current_recip;

  modport source (
    output valid, mode, vtx_id, current_mass, current_recip,
    input  ready
  );
  modport sink (
    input  valid, mode, vtx_id, current_mass, current_recip,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/pvt_rsp_if.sv @@
// Result channel of the pinned vertex table: valid/ready plus payload.
// Depends on nothing.
`default_nettype none

interface pvt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        write_mass;
  logic [31:0] new_mass;
  logic [31:0] new_recip;
  logic [6:0]  pinned_count;

  modport source (
    output valid, status, write_mass, new_mass, new_recip, pinned_count,
    input  ready
  );
  modport sink (
    input  valid, status, write_mass, new_mass, new_recip, pinned_count,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/pvt_cell.sv @@
// One slot of the pinned vertex table row: entry registers and key compare.
// Uses pvt_pkg for the broadcast control struct.
`default_nettype none

module pvt_cell
  import pvt_pkg::*;
#(
  parameter int unsigned INDEX_WIDTH = 20,
  parameter int unsigned COUNT_WIDTH = 7,
  parameter int unsigned POS         = 0
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cell_ctrl_t             ctrl_i,
  input  wire logic [COUNT_WIDTH-1:0] count_i,
  input  wire logic [INDEX_WIDTH-1:0] key_i,
  input  wire logic                   prefix_i,
  input  wire logic [INDEX_WIDTH-1:0] lo_idx_i,
  input  wire logic [31:0]            lo_mass_i,
  input  wire logic [31:0]            lo_inv_i,
  input  wire logic [INDEX_WIDTH-1:0] up_idx_i,
  input  wire logic [31:0]            up_mass_i,
  input  wire logic [31:0]            up_inv_i,
  output logic      [INDEX_WIDTH-1:0] idx_o,
  output logic      [31:0]            mass_o,
  output logic      [31:0]            inv_o,
  output logic                        match_o
);

  logic [INDEX_WIDTH-1:0] idx_q;
  logic [31:0]            mass_q;
  logic [31:0]            inv_q;
  logic                   match_q;
  logic                   in_use;

  assign in_use = (count_i > COUNT_WIDTH'(POS));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_up) begin
      idx_q  <= lo_idx_i;
      mass_q <= lo_mass_i;
      inv_q  <= lo_inv_i;
    end else if (ctrl_i.remove && prefix_i) begin
      idx_q  <= up_idx_i;
      mass_q <= up_mass_i;
      inv_q  <= up_inv_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.capture) begin
      match_q <= in_use && (idx_q == key_i);
    end
  end

  assign idx_o   = idx_q;
  assign mass_o  = mass_q;
  assign inv_o   = inv_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

@@ hdl/pinned_vertex_table.sv @@
// Pinned vertex table: a row of TABLE_DEPTH cells, each holding one pinned
// vertex index with its saved mass and inverse mass, kept packed at the low
// end of the row. In the cycle a request transfers, every cell compares the
// index against its entry; in the next, the sequencer decides the status, the
// row shifts (up by one on pin, down above the hit on unpin) and the result
// lands in the output register. The next request is taken in the cycle after
// that, once the previous result has transferred or transfers in that cycle,
// so no request is taken while another is still being executed. The table is
// empty after reset with no clearing pass; vertex_total is written through
// cfg_we_i/cfg_data_i, by the user only while idle; the block does not check.
`default_nettype none

module pinned_vertex_table
  import pvt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned INDEX_WIDTH = 20
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  pvt_req_if.sink                      req_i,
  pvt_rsp_if.source                    rsp_o,
  input  wire logic                    cfg_we_i,
  input  wire logic [VTOTAL_WIDTH-1:0] cfg_data_i
);

  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LVLS = $clog2(TABLE_DEPTH);
  localparam int unsigned CMPW = (INDEX_WIDTH > VTOTAL_WIDTH) ? INDEX_WIDTH : VTOTAL_WIDTH;

  state_e state_q, state_d;

  logic [VTOTAL_WIDTH-1:0] vtotal_q;
  logic [CW-1:0]           count_q, count_d;

  // registered request
  logic                   mode_q;
  logic [INDEX_WIDTH-1:0] ridx_q;
  logic [31:0]            rmass_q;
  logic [31:0]            rinv_q;

  // output register
  logic          ovalid_q;
  status_e       ostatus_q, ostatus_d;
  logic          owr_q, owr_d;
  logic [31:0]   omass_q, omass_d;
  logic [31:0]   oinv_q, oinv_d;

  logic       accept;
  cell_ctrl_t ctrl;

  logic [INDEX_WIDTH-1:0] c_idx  [TABLE_DEPTH];
  logic [31:0]            c_mass [TABLE_DEPTH];
  logic [31:0]            c_inv  [TABLE_DEPTH];
  logic [INDEX_WIDTH-1:0] lo_idx [TABLE_DEPTH];
  logic [31:0]            lo_mass[TABLE_DEPTH];
  logic [31:0]            lo_inv [TABLE_DEPTH];
  logic [INDEX_WIDTH-1:0] up_idx [TABLE_DEPTH];
  logic [31:0]            up_mass[TABLE_DEPTH];
  logic [31:0]            up_inv [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] match;
  logic [TABLE_DEPTH-1:0] prefix;

  logic        any_hit;
  logic [31:0] hit_mass, hit_inv;
  logic        in_range;

  assign req_i.ready = (state_q == S_IDLE) && (!ovalid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  // ---------------------------------------------------------------- cells
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_lo_head
      assign lo_idx[g]  = ridx_q;
      assign lo_mass[g] = rmass_q;
      assign lo_inv[g]  = rinv_q;
    end else begin : g_lo_link
      assign lo_idx[g]  = c_idx[g-1];
      assign lo_mass[g] = c_mass[g-1];
      assign lo_inv[g]  = c_inv[g-1];
    end
    if (g == TABLE_DEPTH - 1) begin : g_up_tail
      assign up_idx[g]  = '0;
      assign up_mass[g] = '0;
      assign up_inv[g]  = '0;
    end else begin : g_up_link
      assign up_idx[g]  = c_idx[g+1];
      assign up_mass[g] = c_mass[g+1];
      assign up_inv[g]  = c_inv[g+1];
    end

    pvt_cell #(
      .INDEX_WIDTH(INDEX_WIDTH),
      .COUNT_WIDTH(CW),
      .POS        (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .count_i  (count_q),
      .key_i    (req_i.vtx_id),
      .prefix_i (prefix[g]),
      .lo_idx_i (lo_idx[g]),
      .lo_mass_i(lo_mass[g]),
      .lo_inv_i (lo_inv[g]),
      .up_idx_i (up_idx[g]),
      .up_mass_i(up_mass[g]),
      .up_inv_i (up_inv[g]),
      .idx_o    (c_idx[g]),
      .mass_o   (c_mass[g]),
      .inv_o    (c_inv[g]),
      .match_o  (match[g])
    );
  end

  // Prefix OR of the hit vector in log steps: a cell at or above the hit
  // pulls its upper neighbor on removal.
  always_comb begin
    logic [TABLE_DEPTH-1:0] tmp;
    prefix = match;
    for (int l = 0; l < LVLS; l++) begin
      tmp = prefix;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (i >= (1 << l)) begin
          prefix[i] = tmp[i] | tmp[i - (1 << l)];
        end
      end
    end
  end

  // at most one cell hits, so an AND-OR select picks its saved masses
  always_comb begin
    hit_mass = '0;
    hit_inv  = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_mass = hit_mass | ({32{match[i]}} & c_mass[i]);
      hit_inv  = hit_inv  | ({32{match[i]}} & c_inv[i]);
    end
  end

  assign any_hit  = |match;
  assign in_range = CMPW'(ridx_q) < CMPW'(vtotal_q);

  // ------------------------------------------------------------ sequencer
  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    ctrl.capture   = accept;
    ctrl.shift_up  = 1'b0;
    ctrl.remove    = 1'b0;
    ostatus_d      = ST_NOT_PINNED;
    owr_d          = 1'b0;
    omass_d        = '0;
    oinv_d         = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        if (mode_q == MODE_PIN) begin
          priority if (!in_range) begin
            ostatus_d = ST_RANGE;
          end else if (any_hit) begin
            ostatus_d = ST_ALREADY;
          end else if (count_q >= CW'(TABLE_DEPTH)) begin
            ostatus_d = ST_FULL;
          end else begin
            ostatus_d     = ST_PINNED;
            owr_d         = 1'b1;
            omass_d       = PIN_MASS_BITS;
            oinv_d        = PIN_RECIP_BITS;
            ctrl.shift_up = 1'b1;
            count_d       = count_q + CW'(1);
          end
        end else if (any_hit) begin
          ostatus_d   = ST_RESTORED;
          owr_d       = 1'b1;
          omass_d     = hit_mass;
          oinv_d      = hit_inv;
          ctrl.remove = 1'b1;
          count_d     = count_q - CW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      vtotal_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        vtotal_q <= cfg_data_i;
      end
      if (state_q == S_EXEC) begin
        ovalid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // hold payload registers until the next request or result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= req_i.mode;
      ridx_q  <= req_i.vtx_id;
      rmass_q <= req_i.current_mass;
      rinv_q  <= req_i.current_recip;
    end
    if (state_q == S_EXEC) begin
      ostatus_q <= ostatus_d;
      owr_q     <= owr_d;
      omass_q   <= omass_d;
      oinv_q    <= oinv_d;
    end
  end

  assign rsp_o.valid        = ovalid_q;
  assign rsp_o.status       = ostatus_q;
  assign rsp_o.write_mass   = owr_q;
  assign rsp_o.new_mass     = omass_q;
  assign rsp_o.new_recip    = oinv_q;
  assign rsp_o.pinned_count = COUNT_OUT_WIDTH'(count_q);

  // ----------------------------------------------------------- assertions
  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> $onehot0(match))
    else $error("more than one cell holds the same vertex index");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> !ovalid_q)
    else $error("result register still occupied when a result is produced");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q == S_EXEC) && $past(accept, 2))
    else $error("result appeared without a transferred request");

endmodule

`default_nettype wire

@@ sim/pvt_table_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the pinned vertex table: keeps its own copy of the table,
// predicts one result per request transfer and compares it field by field.
// Depends on pvt_pkg and the channel interfaces pvt_req_if and pvt_rsp_if.

module pvt_table_checker
  import pvt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned INDEX_WIDTH = 20
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  pvt_req_if                      req_i,
  pvt_rsp_if                      rsp_i,
  input  logic                    cfg_we_i,
  input  logic [VTOTAL_WIDTH-1:0] cfg_data_i,
  output int                      error_count_o,
  output int                      open_count_o
);

  typedef struct packed {
    status_e                    status;
    logic                       write_mass;
    logic [31:0]                new_mass;
    logic [31:0]                new_recip;
    logic [COUNT_OUT_WIDTH-1:0] pinned_count;
  } pin_result_t;

  logic [INDEX_WIDTH-1:0]  pinned_idx   [TABLE_DEPTH];
  logic [31:0]             pinned_mass  [TABLE_DEPTH];
  logic [31:0]             pinned_recip [TABLE_DEPTH];
  int unsigned             pinned_total;
  logic [VTOTAL_WIDTH-1:0] vertex_limit;
  pin_result_t             expected_q[$];
  int                      errors;

  always @(posedge clk_i or negedge rst_ni) begin : predict_and_compare
    pin_result_t want;
    pin_result_t got;
    int          hit;
    int unsigned last;
    if (!rst_ni) begin
      pinned_total = 0;
      vertex_limit = '0;
      expected_q.delete();
      errors = 0;
      error_count_o <= 0;
      open_count_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        vertex_limit = cfg_data_i;
      end

      // Retire the oldest expectation before queueing a new one in this cycle
      if (rsp_i.valid && rsp_i.ready) begin
        got.status       = status_e'(rsp_i.status);
        got.write_mass   = rsp_i.write_mass;
        got.new_mass     = rsp_i.new_mass;
        got.new_recip    = rsp_i.new_recip;
        got.pinned_count = rsp_i.pinned_count;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: result with nothing pending: status %0d count %0d",
                     $realtime, got.status, got.pinned_count);
          end
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch exp st=%0d wr=%0b m=%h im=%h cnt=%0d",
                       $realtime, want.status, want.write_mass, want.new_mass,
                       want.new_recip, want.pinned_count);
              $display("%0t:          got st=%0d wr=%0b m=%h im=%h cnt=%0d",
                       $realtime, got.status, got.write_mass, got.new_mass,
                       got.new_recip, got.pinned_count);
            end
          end
        end
      end

      if (req_i.valid && req_i.ready) begin
        hit = -1;
        for (int k = 0; k < pinned_total; k++) begin
          if (hit < 0 && pinned_idx[k] == req_i.vtx_id) hit = k;
        end
        want = '0;
        if (mode_e'(req_i.mode) == MODE_PIN) begin
          if (VTOTAL_WIDTH'(req_i.vtx_id) >= vertex_limit) begin
            want.status = ST_RANGE;
          end else if (hit >= 0) begin
            want.status = ST_ALREADY;
          end else if (pinned_total >= TABLE_DEPTH) begin
            want.status = ST_FULL;
          end else begin
            pinned_idx[pinned_total]   = req_i.vtx_id;
            pinned_mass[pinned_total]  = req_i.current_mass;
            pinned_recip[pinned_total] = req_i.current_recip;
            pinned_total++;
            want.status     = ST_PINNED;
            want.write_mass = 1'b1;
            want.new_mass   = PIN_MASS_BITS;
            want.new_recip  = PIN_RECIP_BITS;
          end
        end else if (hit >= 0) begin
          // Hand back the saved masses, then fill the hole with the last entry
          last              = pinned_total - 1;
          want.status       = ST_RESTORED;
          want.write_mass   = 1'b1;
          want.new_mass     = pinned_mass[hit];
          want.new_recip    = pinned_recip[hit];
          pinned_idx[hit]   = pinned_idx[last];
          pinned_mass[hit]  = pinned_mass[last];
          pinned_recip[hit] = pinned_recip[last];
          pinned_total      = last;
        end else begin
          want.status = ST_NOT_PINNED;
        end
        want.pinned_count = pinned_total[COUNT_OUT_WIDTH-1:0];
        expected_q = {expected_q, want};
      end

      error_count_o <= errors;
      open_count_o  <= expected_q.size();
    end
  end

endmodule

@@ sim/tb_pinned_vertex_table.sv @@
`timescale 1ns / 1ps
// Testbench top for the pinned vertex table: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on pvt_pkg, the channel
// interfaces, pinned_vertex_table and pvt_table_checker.

module tb_pinned_vertex_table;
  import pvt_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned INDEX_WIDTH = 20;
  localparam int          STALL_LIMIT = 2000;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we;
  logic [VTOTAL_WIDTH-1:0] cfg_data;
  logic                    rsp_ready = 1'b0;
  logic                    quiet     = 1'b0;
  int                      ready_hold = 0;
  int                      stall_cycles = 0;
  int                      error_count;
  int                      open_count;
  logic [INDEX_WIDTH-1:0]  pinned_hint[$];

  pvt_req_if #(.INDEX_WIDTH(INDEX_WIDTH)) req_ch ();
  pvt_rsp_if                              rsp_ch ();

  assign rsp_ch.ready = rsp_ready;

  pinned_vertex_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .INDEX_WIDTH(INDEX_WIDTH)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_ch),
    .rsp_o     (rsp_ch),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data)
  );

  pvt_table_checker #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .INDEX_WIDTH(INDEX_WIDTH)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .error_count_o(error_count),
    .open_count_o (open_count)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Result back-pressure: random bursts of stall and accept, none once quiet
  always @(posedge clk_i) begin
    if (!rst_ni || quiet) begin
      rsp_ready  <= rst_ni;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 99) < 30) begin
      rsp_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 9);
    end else begin
      rsp_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 19);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_req(input mode_e mode, input logic [INDEX_WIDTH-1:0] idx,
                          input logic [31:0] mass, input logic [31:0] recip);
    req_ch.valid         <= 1'b1;
    req_ch.mode          <= mode;
    req_ch.vtx_id        <= idx;
    req_ch.current_mass  <= mass;
    req_ch.current_recip <= recip;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  // Hold off requests until every pending result has come back
  task automatic drain_pending();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (open_count != 0) @(posedge clk_i);
  endtask

  task automatic set_vertex_total(input logic [VTOTAL_WIDTH-1:0] value);
    drain_pending();
    repeat (3) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [31:0] pick_mass();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return 32'h0000_0000;
    if (sel < 20) return 32'hFFFF_FFFF;
    if (sel < 25) return PIN_MASS_BITS;
    return $urandom();
  endfunction

  task automatic run_phase(input int n_items, input int pin_pct,
                           input logic [VTOTAL_WIDTH-1:0] span, input bit gaps_on);
    mode_e                  mode;
    logic [INDEX_WIDTH-1:0] idx;
    int                     pick;
    for (int i = 0; i < n_items; i++) begin
      mode = ($urandom_range(0, 99) < pin_pct) ? MODE_PIN : MODE_UNPIN;
      pick = $urandom_range(0, 99);
      if (mode == MODE_UNPIN && pinned_hint.size() != 0 && pick < 70) begin
        idx = pinned_hint[$urandom_range(0, pinned_hint.size() - 1)];
      end else if (span != 0 && pick < 80) begin
        idx = INDEX_WIDTH'($urandom_range(0, int'(span) - 1));
      end else if (pick < 88) begin
        // Range boundary: last valid index or first rejected one
        idx = span[INDEX_WIDTH-1:0] - INDEX_WIDTH'(pick % 2);
      end else begin
        idx = INDEX_WIDTH'($urandom());
      end
      if (mode == MODE_PIN) begin
        pinned_hint = {pinned_hint, idx};
        if (pinned_hint.size() > 96) void'(pinned_hint.pop_front());
      end
      send_req(mode, idx, pick_mass(), pick_mass());
      if (gaps_on && $urandom_range(0, 99) < 20) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      if (gaps_on && $urandom_range(0, 149) == 0) drain_pending();
    end
  endtask

  initial begin : stimulus
    rst_ni               <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_data             <= '0;
    req_ch.valid         <= 1'b0;
    req_ch.mode          <= MODE_PIN;
    req_ch.vtx_id        <= '0;
    req_ch.current_mass  <= '0;
    req_ch.current_recip <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty mesh: every pin is out of range, unpin finds nothing
    send_req(MODE_PIN,   20'd0, 32'h3F80_0000, 32'h3F80_0000);
    send_req(MODE_UNPIN, 20'd0, 32'h0, 32'h0);

    set_vertex_total(21'h10_0000);
    send_req(MODE_PIN,   20'hFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(MODE_PIN,   20'h00000, 32'h0000_0000, 32'h0000_0000);
    send_req(MODE_PIN,   20'hFFFFF, 32'h1234_5678, 32'h8765_4321);
    send_req(MODE_UNPIN, 20'hFFFFF, 32'h0, 32'h0);
    send_req(MODE_UNPIN, 20'hFFFFF, 32'h0, 32'h0);
    send_req(MODE_PIN,   20'h55555, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_req(MODE_PIN,   20'hAAAAA, 32'h5A5A_5A5A, 32'hA5A5_A5A5);

    // One-vertex mesh: range check wins over the already-pinned check,
    // while unpin ignores the range entirely
    set_vertex_total(21'd1);
    send_req(MODE_PIN,   20'h00000, 32'hDEAD_BEEF, 32'hCAFE_F00D);
    send_req(MODE_PIN,   20'h00001, 32'hDEAD_BEEF, 32'hCAFE_F00D);
    send_req(MODE_PIN,   20'h55555, 32'hDEAD_BEEF, 32'hCAFE_F00D);
    send_req(MODE_UNPIN, 20'h55555, 32'h0, 32'h0);
    send_req(MODE_UNPIN, 20'hFFFFF, 32'h0, 32'h0);
    send_req(MODE_UNPIN, 20'h00000, 32'h0, 32'h0);

    set_vertex_total(21'd200);
    run_phase(300, 60, 21'd200, 1'b1);
    set_vertex_total(21'h10_0000);
    run_phase(250, 80, 21'h10_0000, 1'b1);
    set_vertex_total(21'd0);
    run_phase(60, 40, 21'd0, 1'b1);
    set_vertex_total(21'h10_0000);
    run_phase(200, 25, 21'h10_0000, 1'b1);
    set_vertex_total(21'd64);
    run_phase(100, 60, 21'd64, 1'b1);
    quiet <= 1'b1;
    run_phase(100, 60, 21'd64, 1'b0);

    drain_pending();
    repeat (10) @(posedge clk_i);
    if (error_count == 0 && open_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
